@@ rtl/core/dtic_pkg.sv @@
// ----------------------------------------------------------------------------
// dtic_pkg - shared types and constants for the decimal text to int64 cast
// Character classes, queue entry layout, queue status and numeric limits.
// ----------------------------------------------------------------------------
package dtic_pkg;

	// queue between the classifier and the parser
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [63:0] MIN_MAG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] UMAX    = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [67:0] RADIX   = 68'd10;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// byte class as decided by the front end
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_BLANK,
		CLS_PLUS,
		CLS_MINUS,
		CLS_DIGIT,
		CLS_OTHER
	} char_cls_t;

	typedef struct packed {
		char_cls_t   cls;
		logic [3:0]  digit;
		logic        last;
		logic        uns;
	} item_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
		logic           empty;
	} q_stat_t;

endpackage

@@ rtl/core/dtic_if.sv @@
// ----------------------------------------------------------------------------
// dtic_if - channel interfaces for the decimal text to int64 cast
// Valid/ready channels for the text beats and for the result beats.
// ----------------------------------------------------------------------------
interface dtic_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       byte_present;
	logic       end_of_text;
	logic       to_unsigned;

	modport source(output valid, char_byte, byte_present, end_of_text, to_unsigned,
		input ready);
	modport sink(input valid, char_byte, byte_present, end_of_text, to_unsigned,
		output ready);
endinterface

interface dtic_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;
	logic        truncated_warning;
	logic        complement_warning;

	modport source(output valid, value_bits, truncated_warning, complement_warning,
		input ready);
	modport sink(input valid, value_bits, truncated_warning, complement_warning,
		output ready);
endinterface

@@ rtl/core/dtic_front.sv @@
// ----------------------------------------------------------------------------
// dtic_front - input classifier
// Accepts text beats and sorts each byte into a class for the parser.
// ----------------------------------------------------------------------------
module dtic_front (
	dtic_in_if.sink         in_ch,
	input  logic            full,
	output logic            push,
	output dtic_pkg::item_t item
);

	logic [7:0] b;
	logic       is_blank;
	logic       is_digit;

	assign b        = in_ch.char_byte;
	assign is_blank = (b == dtic_pkg::CH_SPACE) ||
		((b >= dtic_pkg::CH_TAB) && (b <= dtic_pkg::CH_CR));
	assign is_digit = (b >= dtic_pkg::CH_ZERO) && (b <= dtic_pkg::CH_NINE);

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	// classify the byte
	always_comb begin
		item.digit = b[3:0];
		item.last  = in_ch.end_of_text;
		item.uns   = in_ch.to_unsigned;
		if (!in_ch.byte_present) begin
			item.cls = dtic_pkg::CLS_NONE;
		end else if (is_blank) begin
			item.cls = dtic_pkg::CLS_BLANK;
		end else if (b == dtic_pkg::CH_PLUS) begin
			item.cls = dtic_pkg::CLS_PLUS;
		end else if (b == dtic_pkg::CH_MINUS) begin
			item.cls = dtic_pkg::CLS_MINUS;
		end else if (is_digit) begin
			item.cls = dtic_pkg::CLS_DIGIT;
		end else begin
			item.cls = dtic_pkg::CLS_OTHER;
		end
	end

endmodule

@@ rtl/core/dtic_queue.sv @@
// ----------------------------------------------------------------------------
// dtic_queue - classified beat queue
// Small FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module dtic_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtic_pkg::item_t   wr_item,
	input  logic              pop,
	output dtic_pkg::item_t   rd_item,
	output dtic_pkg::q_stat_t stat
);

	dtic_pkg::item_t               mem_q [dtic_pkg::QDEPTH];
	logic [dtic_pkg::QAW-1:0]      wr_ptr_q;
	logic [dtic_pkg::QAW-1:0]      rd_ptr_q;
	logic [dtic_pkg::QCW-1:0]      count_q;

	assign stat.count = count_q;
	assign stat.full  = (count_q == dtic_pkg::QCW'(dtic_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/dtic_back.sv @@
// ----------------------------------------------------------------------------
// dtic_back - parser and result stage
// Runs the parse state machine, saturating accumulate and final cast.
// ----------------------------------------------------------------------------
module dtic_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dtic_pkg::item_t item,
	input  logic            empty,
	output logic            pop,
	dtic_out_if.source      out_ch
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_TRAIL,
		PH_JUNK
	} phase_t;

	// parse state
	phase_t      phase_q;
	logic        neg_q;
	logic        digits_q;
	logic        ovf_q;
	logic        junk_q;
	logic [63:0] mag_q;

	// finished string, waiting for the cast
	logic        valid_s1;
	logic        neg_s1;
	logic        digits_s1;
	logic        ovf_s1;
	logic        junk_s1;
	logic        uns_s1;
	logic [63:0] mag_s1;

	// result register
	logic        valid_s2;
	logic [63:0] value_s2;
	logic        trunc_s2;
	logic        comp_s2;

	phase_t      phase_n;
	logic        neg_n;
	logic        digits_n;
	logic        ovf_n;
	logic        junk_n;
	logic [63:0] mag_n;
	logic [67:0] sum;
	logic [67:0] limit;
	logic        out_go;
	logic        fin_go;
	logic        take_digit;

	assign out_go = !valid_s2 || out_ch.ready;
	assign fin_go = !valid_s1 || out_go;
	assign pop    = !empty && (!item.last || fin_go);

	// next-digit accumulate with saturation check
	assign limit = neg_q ? {4'b0, dtic_pkg::MIN_MAG} : {4'b0, dtic_pkg::UMAX};
	assign sum   = {4'b0, mag_q} * dtic_pkg::RADIX + {64'b0, item.digit};

	// next parse state for the beat at the queue head
	always_comb begin
		phase_n    = phase_q;
		neg_n      = neg_q;
		junk_n     = junk_q;
		take_digit = 1'b0;
		if (item.cls != dtic_pkg::CLS_NONE) begin
			case (phase_q)
				PH_LEAD: begin
					case (item.cls)
						dtic_pkg::CLS_BLANK: ;
						dtic_pkg::CLS_PLUS: begin
							neg_n   = 1'b0;
							phase_n = PH_SIGN;
						end
						dtic_pkg::CLS_MINUS: begin
							neg_n   = 1'b1;
							phase_n = PH_SIGN;
						end
						dtic_pkg::CLS_DIGIT: begin
							take_digit = 1'b1;
							phase_n    = PH_DIGITS;
						end
						default: begin
							phase_n = PH_JUNK;
							junk_n  = 1'b1;
						end
					endcase
				end
				PH_SIGN: begin
					if (item.cls == dtic_pkg::CLS_DIGIT) begin
						take_digit = 1'b1;
						phase_n    = PH_DIGITS;
					end else begin
						phase_n = PH_JUNK;
						junk_n  = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (item.cls == dtic_pkg::CLS_DIGIT) begin
						take_digit = 1'b1;
					end else if (item.cls == dtic_pkg::CLS_BLANK) begin
						phase_n = PH_TRAIL;
					end else begin
						phase_n = PH_JUNK;
						junk_n  = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (item.cls != dtic_pkg::CLS_BLANK) begin
						phase_n = PH_JUNK;
						junk_n  = 1'b1;
					end
				end
				default: begin
					phase_n = PH_JUNK;
					junk_n  = 1'b1;
				end
			endcase
		end
		digits_n = digits_q || take_digit;
		ovf_n    = ovf_q;
		mag_n    = mag_q;
		if (take_digit && !ovf_q) begin
			if (sum > limit) begin
				ovf_n = 1'b1;
				mag_n = limit[63:0];
			end else begin
				mag_n = sum[63:0];
			end
		end
	end

	// parse state, cast stage and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEAD;
			neg_q     <= 1'b0;
			digits_q  <= 1'b0;
			ovf_q     <= 1'b0;
			junk_q    <= 1'b0;
			mag_q     <= '0;
			valid_s1  <= 1'b0;
			neg_s1    <= 1'b0;
			digits_s1 <= 1'b0;
			ovf_s1    <= 1'b0;
			junk_s1   <= 1'b0;
			uns_s1    <= 1'b0;
			mag_s1    <= '0;
			valid_s2  <= 1'b0;
			value_s2  <= '0;
			trunc_s2  <= 1'b0;
			comp_s2   <= 1'b0;
		end else begin
			if (pop) begin
				if (item.last) begin
					// string ends: hand off and start clean
					phase_q   <= PH_LEAD;
					neg_q     <= 1'b0;
					digits_q  <= 1'b0;
					ovf_q     <= 1'b0;
					junk_q    <= 1'b0;
					mag_q     <= '0;
					neg_s1    <= neg_n;
					digits_s1 <= digits_n;
					ovf_s1    <= ovf_n;
					junk_s1   <= junk_n;
					uns_s1    <= item.uns;
					mag_s1    <= digits_n ? mag_n : '0;
				end else begin
					phase_q  <= phase_n;
					neg_q    <= neg_n;
					digits_q <= digits_n;
					ovf_q    <= ovf_n;
					junk_q   <= junk_n;
					mag_q    <= mag_n;
				end
			end
			if (fin_go) begin
				valid_s1 <= pop && item.last;
			end
			if (out_go) begin
				valid_s2 <= valid_s1;
				value_s2 <= neg_s1 ? (64'd0 - mag_s1) : mag_s1;
				trunc_s2 <= !digits_s1 || ovf_s1 || junk_s1;
				comp_s2  <= uns_s1 ? (neg_s1 && digits_s1 && !ovf_s1)
					: (!neg_s1 && !ovf_s1 && mag_s1[63]);
			end
		end
	end

	assign out_ch.valid              = valid_s2;
	assign out_ch.value_bits         = value_s2;
	assign out_ch.truncated_warning  = trunc_s2;
	assign out_ch.complement_warning = comp_s2;

endmodule

@@ rtl/core/decimal_text_to_int64_cast_top.sv @@
// The beat ending a string passes the queue, the cast stage and the result register
// in turn; result-side back-pressure can hold it in the queue or in either stage.
// Throughput: one text beat per cycle while the queue is not full; the parser's
// combinational multiply-by-ten, add and limit compare set that rate; a 4-beat queue lets input run ahead.
// Reset: arst_n clears the queue, the parse state and both result stages at once.
// ----------------------------------------------------------------------------
// decimal_text_to_int64_cast_top - saturating decimal text to int64 cast
// Classifier front end, beat queue and parser/cast back end.
// ----------------------------------------------------------------------------
module decimal_text_to_int64_cast_top (
	input  logic       clk,
	input  logic       arst_n,
	dtic_in_if.sink    in_ch,
	dtic_out_if.source out_ch
);

	logic              push;
	logic              pop;
	dtic_pkg::item_t   wr_item;
	dtic_pkg::item_t   rd_item;
	dtic_pkg::q_stat_t q_stat;

	dtic_front u_front (
		.in_ch (in_ch),
		.full  (q_stat.full),
		.push  (push),
		.item  (wr_item)
	);

	dtic_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.stat    (q_stat)
	);

	dtic_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (rd_item),
		.empty  (q_stat.empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// a full queue must hold off the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ch.ready)
		else $error("queue full but input ready");

	// the parser never reads an empty queue
	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> !pop)
		else $error("pop from empty queue");

	// fill count advances on a push without a pop
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

@@ dv/dtic_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtic_checker - result predictor and scoreboard for the text to int64 cast
// Watches both channels. Every accepted text beat runs through a cycle-free
// copy of the parser, and the beat that ends a string queues the expected
// cast. Every accepted result beat is compared field by field with the
// oldest queued cast. The failure count and the number of casts still owed
// go back to the testbench top.
// ----------------------------------------------------------------------------
module dtic_checker (
	input  logic clk,
	input  logic arst_n,
	dtic_in_if   in_ch,
	dtic_out_if  out_ch,
	output int   fail_count,
	output int   pending
);
	import dtic_pkg::*;

	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_SIGN,
		SCAN_DIGITS,
		SCAN_TRAIL,
		SCAN_JUNK
	} scan_phase_t;

	typedef struct packed {
		logic [63:0] value;
		logic        trunc;
		logic        comp;
	} cast_result_t;

	// predicted parse state for the string in flight
	scan_phase_t  phase;
	logic         neg;
	logic         got_digit;
	logic         ovf;
	logic         junk;
	logic [63:0]  mag;
	cast_result_t cast_expect_q[$];

	function automatic logic is_blank(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	task automatic clear_scan();
		phase     = SCAN_LEAD;
		neg       = 1'b0;
		got_digit = 1'b0;
		ovf       = 1'b0;
		junk      = 1'b0;
		mag       = '0;
	endtask

	task automatic go_junk();
		phase = SCAN_JUNK;
		junk  = 1'b1;
	endtask

	// multiply-by-ten and add, saturating at the limit for the sign
	task automatic accumulate(logic [7:0] b);
		logic [63:0] d;
		logic [63:0] lim;
		d         = {56'd0, b - CH_ZERO};
		lim       = neg ? MIN_MAG : UMAX;
		got_digit = 1'b1;
		if (!ovf) begin
			if (mag > (lim - d) / 64'd10) begin
				ovf = 1'b1;
				mag = lim;
			end else begin
				mag = mag * 64'd10 + d;
			end
		end
	endtask

	task automatic scan_byte(logic [7:0] b);
		case (phase)
		SCAN_LEAD: begin
			if (b == CH_PLUS || b == CH_MINUS) begin
				neg   = (b == CH_MINUS);
				phase = SCAN_SIGN;
			end else if (is_digit(b)) begin
				accumulate(b);
				phase = SCAN_DIGITS;
			end else if (!is_blank(b)) begin
				go_junk();
			end
		end
		SCAN_SIGN: begin
			if (is_digit(b)) begin
				accumulate(b);
				phase = SCAN_DIGITS;
			end else begin
				go_junk();
			end
		end
		SCAN_DIGITS: begin
			if (is_digit(b))
				accumulate(b);
			else if (is_blank(b))
				phase = SCAN_TRAIL;
			else
				go_junk();
		end
		SCAN_TRAIL: begin
			if (!is_blank(b))
				go_junk();
		end
		default: go_junk();
		endcase
	endtask

	// cast of the finished string for the target sampled on its last beat
	function automatic cast_result_t finish_cast(logic uns);
		cast_result_t r;
		logic [63:0]  m;
		m       = got_digit ? mag : '0;
		r.value = neg ? (64'd0 - m) : m;
		r.trunc = !got_digit || ovf || junk;
		if (uns)
			r.comp = neg && got_digit && !ovf;
		else
			r.comp = !neg && !ovf && m > (MIN_MAG - 64'd1);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cast_result_t want;
		if (!arst_n) begin
			clear_scan();
			cast_expect_q.delete();
			fail_count = 0;
		end else begin
			// text beat
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.byte_present)
					scan_byte(in_ch.char_byte);
				if (in_ch.end_of_text) begin
					cast_expect_q.push_back(finish_cast(in_ch.to_unsigned));
					clear_scan();
				end
			end
			// result beat
			if (out_ch.valid && out_ch.ready) begin
				if (cast_expect_q.size() == 0) begin
					$display("%0t: result beat with no string ended, value_bits %h",
						$time, out_ch.value_bits);
					fail_count++;
				end else begin
					want = cast_expect_q.pop_front();
					if (out_ch.value_bits !== want.value) begin
						$display("%0t: value_bits expected %h got %h",
							$time, want.value, out_ch.value_bits);
						fail_count++;
					end
					if (out_ch.truncated_warning !== want.trunc) begin
						$display("%0t: truncated_warning expected %b got %b",
							$time, want.trunc, out_ch.truncated_warning);
						fail_count++;
					end
					if (out_ch.complement_warning !== want.comp) begin
						$display("%0t: complement_warning expected %b got %b",
							$time, want.comp, out_ch.complement_warning);
						fail_count++;
					end
				end
			end
		end
		pending = cast_expect_q.size();
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for decimal_text_to_int64_cast_top
// Sends a few hand-picked strings, then random strings: mostly well-formed
// numbers, small, wide or near the 64-bit limits, plus junk, stray signs and
// noise. Both channels idle at random; the result side also holds off long
// enough to fill the block. Checking lives in dtic_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import dtic_pkg::*;

	localparam int TEXT_BEATS   = 550;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 100000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	int   beats_sent;
	int   gap_max;
	logic [7:0] text_q[$];

	dtic_in_if  in_ch();
	dtic_out_if out_ch();

	decimal_text_to_int64_cast_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	dtic_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] pick_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
	endfunction

	task automatic put_blanks(input int n);
		repeat (n) text_q.push_back(pick_blank());
	endtask

	task automatic put_decimal(input logic [63:0] v);
		logic [7:0] rev[$];
		do begin
			rev.push_back(CH_ZERO + 8'(v % 64'd10));
			v = v / 64'd10;
		end while (v != 0);
		while (rev.size() > 0)
			text_q.push_back(rev.pop_back());
	endtask

	// small, wide, or at a limit with the last digit redrawn and sometimes more digits added
	task automatic put_number();
		logic [63:0] anchor;
		case ($urandom_range(0, 3))
		0: put_decimal(64'($urandom_range(0, 99999)));
		1: put_decimal({$urandom, $urandom} >> $urandom_range(0, 63));
		default: begin
			case ($urandom_range(0, 2))
			0: anchor = UMAX;
			1: anchor = MIN_MAG;
			default: anchor = MIN_MAG - 64'd1;
			endcase
			put_decimal(anchor);
			text_q[$] = CH_ZERO + 8'($urandom_range(0, 9));
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		endcase
	endtask

	task automatic put_sign();
		text_q.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
	endtask

	// one random string into text_q
	task automatic build_text();
		int kind;
		int pos;
		text_q.delete();
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			put_blanks($urandom_range(0, 2));
			if ($urandom_range(0, 2) != 0)
				put_sign();
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
			put_number();
			put_blanks($urandom_range(0, 2));
		end
		case (kind)
		6: begin
			pos = $urandom_range(0, text_q.size() - 1);
			text_q.insert(pos, 8'($urandom));
		end
		7: begin
			text_q.push_back(8'($urandom));
			if ($urandom_range(0, 1) == 0)
				put_sign();
			put_number();
		end
		8: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
		9: begin
			put_blanks($urandom_range(0, 1));
			put_sign();
			case ($urandom_range(0, 2))
			0: put_sign();
			1: text_q.push_back(pick_blank());
			default: ;
			endcase
			if ($urandom_range(0, 1) == 0)
				put_number();
		end
		default: ;
		endcase
	endtask

	// one text beat; holds valid until the block takes it
	task automatic send_beat(input logic [7:0] ch, input logic present,
		input logic last, input logic uns);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.char_byte    <= ch;
		in_ch.byte_present <= present;
		in_ch.end_of_text  <= last;
		in_ch.to_unsigned  <= uns;
		in_ch.valid        <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		beats_sent++;
	endtask

	// text_q as beats, with stray empty beats and an optional bare terminator
	task automatic send_text(input logic uns, input logic split_end);
		logic last;
		for (int i = 0; i < text_q.size(); i++) begin
			if ($urandom_range(0, 11) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0, 1'($urandom));
			last = (i == text_q.size() - 1) && !split_end;
			send_beat(text_q[i], 1'b1, last, last ? uns : 1'($urandom));
		end
		if (split_end || text_q.size() == 0)
			send_beat(8'($urandom), 1'b0, 1'b1, uns);
	endtask

	// result side: random stalls, two long hold-offs to back up the block
	initial begin
		int stall;
		int taken;
		int stall_max;
		taken        = 0;
		stall_max    = 12;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 16 == 0)
				stall_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
			if (taken == 0 || taken == 40)
				stall = HOLD_CYCLES;
			else
				stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		in_ch.valid        = 1'b0;
		in_ch.char_byte    = '0;
		in_ch.byte_present = 1'b0;
		in_ch.end_of_text  = 1'b0;
		in_ch.to_unsigned  = 1'b0;
		arst_n             = 1'b0;
		beats_sent         = 0;
		gap_max            = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-picked strings, back to back while the result side holds off
		text_q.delete();
		send_text(1'b0, 1'b0);                    // empty string
		text_q = '{CH_MINUS, CH_ZERO};
		send_text(1'b1, 1'b0);                    // minus zero, unsigned target
		text_q = '{CH_TAB, CH_PLUS, 8'h39};
		send_text(1'b0, 1'b1);                    // bare terminator beat
		text_q = '{8'hFF, 8'h31};
		send_text(1'b0, 1'b0);                    // digit after junk
		send_beat(8'h5A, 1'b0, 1'b0, 1'b1);       // empty beat mid-stream
		text_q = '{8'h35, CH_CR};
		send_text(1'b1, 1'b0);                    // trailing blank
		text_q = '{CH_MINUS};
		send_text(1'b0, 1'b0);                    // sign only
		text_q.delete();
		put_decimal(UMAX);
		text_q[$] = 8'h36;
		send_text(1'b1, 1'b0);                    // one past the unsigned limit

		// random strings
		while (beats_sent < TEXT_BEATS) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			build_text();
			send_text(1'($urandom), 1'($urandom_range(0, 3) == 0));
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ decimal_text_to_int64_cast_top.f @@
rtl/core/dtic_pkg.sv
rtl/core/dtic_if.sv
rtl/core/dtic_front.sv
rtl/core/dtic_queue.sv
rtl/core/dtic_back.sv
rtl/core/decimal_text_to_int64_cast_top.sv
dv/dtic_checker.sv
dv/tb_top.sv
